// ===== hw/rtl/acfb_pkg.sv =====
// Package with the shared types, constants and CRC step function of the aim command frame builder.
`default_nettype none
package acfb_pkg;

    localparam int FRAME_LEN = 13;
    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam int IN_W = 80;

    localparam logic [7:0] HEADER_BYTE = 8'h53;
    localparam logic [7:0] TRAILER_BYTE = 8'h45;
    localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef struct packed {
        logic [7:0] data;
        logic       crc_slot;
        logic       last;
    } t_cell;

    localparam t_cell CELL_EMPTY = '{data: 8'h00, crc_slot: 1'b0, last: 1'b0};

    // One byte of CRC-8/MAXIM, processed LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/acfb_cell.sv =====
// One byte cell of the frame shift chain.
`default_nettype none
module acfb_cell (
    input  wire logic            i_clk,
    input  wire logic            i_load,
    input  wire logic            i_shift,
    input  wire acfb_pkg::t_cell i_load_val,
    input  wire acfb_pkg::t_cell i_next_val,
    output acfb_pkg::t_cell      o_val
);

    acfb_pkg::t_cell r_val;
    acfb_pkg::t_cell n_val;

    always_comb begin
        priority if (i_load) begin
            n_val = i_load_val;
        end else if (i_shift) begin
            n_val = i_next_val;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
`default_nettype wire

// ===== hw/rtl/acfb_crc.sv =====
// CRC-8 accumulator that follows the bytes leaving the head of the chain.
`default_nettype none
module acfb_crc (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire acfb_pkg::t_cell i_head,
    output logic [7:0]           o_crc
);

    logic [7:0] r_acc;
    logic [7:0] n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_take) begin
            priority if (i_head.crc_slot || i_head.last) begin
                n_acc = acfb_pkg::CRC_INIT;
            end else begin
                n_acc = acfb_pkg::crc8_byte(r_acc, i_head.data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= acfb_pkg::CRC_INIT;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_crc = r_acc;

endmodule
`default_nettype wire

// ===== hw/rtl/aim_command_frame_builder_crc8.sv =====
// Top level of the aim command frame builder: loads a report into a byte chain and streams it.
//
//  channel | dir | handshake                | payload
//  s       | in  | i_s_tvalid / o_s_tready  | i_s_tdata: one target report
//  m       | out | o_m_tvalid / i_m_tready  | o_m_tdata: frame byte, o_m_tlast: trailer
//
// A report is loaded in parallel into 13 byte cells and shifted out one byte per cycle unless
// the output stalls. The CRC byte is formed as the header and data bytes leave the chain head.
// A new report is taken in the cycle the last cell empties, so frames follow back to back.
// Reset clears the cell count, the output valid and the CRC accumulator.
// A stall on the output holds the chain and the output register.
`default_nettype none
module aim_command_frame_builder_crc8 (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // target_found, fire_request, yaw_sign, yaw_value, pitch_sign, pitch_value, target_depth
    input  wire logic [acfb_pkg::IN_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // frame_byte
    output logic [7:0]                       o_m_tdata,
    output logic                             o_m_tlast
);

    localparam int N = acfb_pkg::FRAME_LEN;

    logic [acfb_pkg::CNT_W-1:0] r_count;
    logic [acfb_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    logic [7:0]                 r_out_data;
    logic                       r_out_last;
    logic                       advance;
    logic                       load;
    logic                       take;
    logic [7:0]                 crc;
    acfb_pkg::t_cell            load_val [N];
    acfb_pkg::t_cell            cell_val [N];

    assign advance = !r_out_valid || i_m_tready;
    assign take = advance && (r_count != '0);
    assign o_s_tready = (r_count == '0) ||
                        ((r_count == acfb_pkg::CNT_W'(1)) && advance);
    assign load = i_s_tvalid && o_s_tready;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            load_val[k] = acfb_pkg::CELL_EMPTY;
        end
        load_val[0].data  = acfb_pkg::HEADER_BYTE;
        load_val[1].data  = i_s_tdata[7:0];
        load_val[2].data  = i_s_tdata[15:8];
        load_val[3].data  = i_s_tdata[23:16];
        load_val[4].data  = i_s_tdata[31:24];
        load_val[5].data  = i_s_tdata[39:32];
        load_val[6].data  = i_s_tdata[47:40];
        load_val[7].data  = i_s_tdata[55:48];
        load_val[8].data  = i_s_tdata[63:56];
        load_val[9].data  = i_s_tdata[71:64];
        load_val[10].data = i_s_tdata[79:72];
        load_val[11].crc_slot = 1'b1;
        load_val[12].data = acfb_pkg::TRAILER_BYTE;
        load_val[12].last = 1'b1;
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        acfb_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (load),
            .i_shift    (take),
            .i_load_val (load_val[k]),
            .i_next_val ((k == N - 1) ? acfb_pkg::CELL_EMPTY : cell_val[(k + 1) % N]),
            .o_val      (cell_val[k])
        );
    end

    acfb_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_head  (cell_val[0]),
        .o_crc   (crc)
    );

    always_comb begin
        n_count = r_count;
        if (load) begin
            n_count = acfb_pkg::CNT_W'(N);
        end else if (take) begin
            n_count = r_count - acfb_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (advance) begin
                r_out_valid <= take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_data <= cell_val[0].crc_slot ? crc : cell_val[0].data;
            r_out_last <= cell_val[0].last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire
